>>> design/lcdst_pkg.sv
// lcdst_pkg: shared types and timing constants for the scanline timing generator
// no dependencies; used by lcdst_line_step, lcd_scanline_timing_generator_unit and lcdst_status_checker
package lcdst_pkg;

    localparam int unsigned ACCUM_W = 12;
    localparam int unsigned LINE_W  = 8;

    localparam logic [ACCUM_W-1:0] DRAW_END   = 12'd960;
    localparam logic [ACCUM_W-1:0] LINE_LEN   = 12'd1232;
    localparam logic [ACCUM_W-1:0] LINE_LEN_2 = 12'd2464;
    localparam logic [ACCUM_W-1:0] LINE_LEN_3 = 12'd3696;

    localparam logic [LINE_W:0] VISIBLE_LINES = 9'd160;
    localparam logic [LINE_W:0] TOTAL_LINES   = 9'd228;

    localparam logic [1:0] PHASE_CODE_DRAW   = 2'd0;
    localparam logic [1:0] PHASE_CODE_HBLANK = 2'd1;
    localparam logic [1:0] PHASE_CODE_VBLANK = 2'd2;

    typedef enum logic [2:0] {
        PH_DRAW   = 3'b001,
        PH_HBLANK = 3'b010,
        PH_VBLANK = 3'b100
    } t_phase;

    typedef struct packed {
        logic [ACCUM_W-1:0] accum;
        t_phase             phase;
        logic [LINE_W-1:0]  line;
        logic               vblank;
        logic               hblank;
        logic               match;
    } t_timing_state;

    typedef struct packed {
        logic draw_line;
        logic frame_ready;
    } t_events;

endpackage

>>> design/lcdst_line_step.sv
// lcdst_line_step: next-state logic of the scanline timing, one update per call
// depends on lcdst_pkg
module lcdst_line_step (
    input  lcdst_pkg::t_timing_state        i_state,
    input  logic [lcdst_pkg::ACCUM_W-1:0]   i_add,
    input  logic [lcdst_pkg::LINE_W-1:0]    i_line_compare,
    output lcdst_pkg::t_timing_state        o_state,
    output lcdst_pkg::t_events              o_events
);

    logic [lcdst_pkg::ACCUM_W-1:0] sum;
    logic [lcdst_pkg::ACCUM_W-1:0] wrapped;
    logic [lcdst_pkg::LINE_W:0]    next_line;
    logic [lcdst_pkg::LINE_W-1:0]  stored_line;
    logic                          line_end;

    always_comb begin
        sum = i_state.accum + i_add;
        if (sum >= lcdst_pkg::LINE_LEN_3) begin
            wrapped = sum - lcdst_pkg::LINE_LEN_3;
        end else if (sum >= lcdst_pkg::LINE_LEN_2) begin
            wrapped = sum - lcdst_pkg::LINE_LEN_2;
        end else if (sum >= lcdst_pkg::LINE_LEN) begin
            wrapped = sum - lcdst_pkg::LINE_LEN;
        end else begin
            wrapped = sum;
        end

        next_line   = {1'b0, i_state.line} + 9'd1;
        stored_line = (next_line >= lcdst_pkg::TOTAL_LINES) ? '0
                                                             : next_line[lcdst_pkg::LINE_W-1:0];
        line_end    = (sum >= lcdst_pkg::LINE_LEN);

        o_state       = i_state;
        o_state.accum = sum;
        o_events      = '0;

        case (i_state.phase)
            lcdst_pkg::PH_HBLANK: begin
                if (line_end) begin
                    o_state.accum = wrapped;
                    o_state.line  = stored_line;
                    o_state.match = (stored_line == i_line_compare);
                    o_state.hblank = 1'b0;
                    if (next_line == lcdst_pkg::VISIBLE_LINES) begin
                        o_state.phase  = lcdst_pkg::PH_VBLANK;
                        o_state.vblank = 1'b1;
                        o_events.frame_ready = 1'b1;
                    end else begin
                        o_state.phase  = lcdst_pkg::PH_DRAW;
                        o_state.vblank = 1'b0;
                    end
                end
            end
            lcdst_pkg::PH_VBLANK: begin
                if (line_end) begin
                    o_state.accum = wrapped;
                    o_state.line  = stored_line;
                    o_state.match = (stored_line == i_line_compare);
                    if (next_line == lcdst_pkg::TOTAL_LINES) begin
                        o_state.phase  = lcdst_pkg::PH_DRAW;
                        o_state.vblank = 1'b0;
                        o_state.hblank = 1'b0;
                    end
                end
            end
            default: begin
                if (sum >= lcdst_pkg::DRAW_END) begin
                    o_state.phase  = lcdst_pkg::PH_HBLANK;
                    o_state.hblank = 1'b1;
                    o_state.vblank = 1'b0;
                    o_events.draw_line = 1'b1;
                end
            end
        endcase
    end

endmodule

>>> design/lcd_scanline_timing_generator_unit.sv
// lcd_scanline_timing_generator_unit: scanline timing top level with output register
// output: a result is registered and becomes valid in the cycle after its input transaction is accepted
// rate: one transaction per cycle while the output register is not held by back-pressure
// o_in_ready stays high while the output register is empty or being drained
// reset (synchronous, active low) clears timing state, line compare and output valid
// depends on lcdst_pkg and lcdst_line_step
module lcd_scanline_timing_generator_unit #(
    parameter int unsigned ELAPSED_BITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [9:0] i_elapsed_cycles,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_line_compare,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_line_number,
    output logic [1:0] o_phase,
    output logic       o_vblank_flag,
    output logic       o_hblank_flag,
    output logic       o_line_match,
    output logic       o_draw_line,
    output logic       o_frame_ready
);

    lcdst_pkg::t_timing_state      r_state;
    lcdst_pkg::t_timing_state      n_state;
    lcdst_pkg::t_events            n_events;
    logic [7:0]                    r_line_compare;
    logic                          r_out_valid;
    logic [lcdst_pkg::ACCUM_W-1:0] add;
    logic                          in_fire;
    logic [1:0]                    phase_code;

    logic [7:0] r_line_number;
    logic [1:0] r_phase;
    logic       r_vblank;
    logic       r_hblank;
    logic       r_match;
    logic       r_draw_line;
    logic       r_frame_ready;

    assign add = {{(lcdst_pkg::ACCUM_W-ELAPSED_BITS){1'b0}},
                  i_elapsed_cycles[ELAPSED_BITS-1:0]};

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    lcdst_line_step u_step (
        .i_state        (r_state),
        .i_add          (add),
        .i_line_compare (r_line_compare),
        .o_state        (n_state),
        .o_events       (n_events)
    );

    always_comb begin
        case (n_state.phase)
            lcdst_pkg::PH_HBLANK: phase_code = lcdst_pkg::PHASE_CODE_HBLANK;
            lcdst_pkg::PH_VBLANK: phase_code = lcdst_pkg::PHASE_CODE_VBLANK;
            default:              phase_code = lcdst_pkg::PHASE_CODE_DRAW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= '{accum: '0, phase: lcdst_pkg::PH_DRAW, line: '0,
                                vblank: 1'b0, hblank: 1'b0, match: 1'b0};
            r_line_compare <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_compare <= i_cfg_line_compare;
            end
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_line_number <= n_state.line;
            r_phase       <= phase_code;
            r_vblank      <= n_state.vblank;
            r_hblank      <= n_state.hblank;
            r_match       <= n_state.match;
            r_draw_line   <= n_events.draw_line;
            r_frame_ready <= n_events.frame_ready;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_line_number;
    assign o_phase       = r_phase;
    assign o_vblank_flag = r_vblank;
    assign o_hblank_flag = r_hblank;
    assign o_line_match  = r_match;
    assign o_draw_line   = r_draw_line;
    assign o_frame_ready = r_frame_ready;

    // draw end always lands in horizontal blank
    a_draw_in_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw_line) |->
            (o_phase == lcdst_pkg::PHASE_CODE_HBLANK && o_hblank_flag))
        else $error("draw_line outside horizontal blank");

    // frame ready only on the first blank line
    a_frame_at_160: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_ready) |->
            (o_line_number == 8'd160 && o_vblank_flag &&
             o_phase == lcdst_pkg::PHASE_CODE_VBLANK))
        else $error("frame_ready off the first vblank line");

    // vblank status bit tracks the vblank phase
    a_vblank_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == lcdst_pkg::PH_VBLANK) == r_state.vblank)
        else $error("vblank bit out of step with phase");

    // line count stays inside the frame
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line < 8'd228)
        else $error("line count out of range");

endmodule

>>> tb/lcdst_status_checker.sv
`timescale 1ns / 1ps
// lcdst_status_checker: watches the timing, config and status channels, predicts every status
// transaction and compares it field by field; depends on lcdst_pkg
module lcdst_status_checker #(
    parameter int unsigned ELAPSED_BITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [9:0] i_elapsed_cycles,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_line_compare,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_line_number,
    input  logic [1:0] i_phase,
    input  logic       i_vblank_flag,
    input  logic       i_hblank_flag,
    input  logic       i_line_match,
    input  logic       i_draw_line,
    input  logic       i_frame_ready,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        logic [lcdst_pkg::LINE_W-1:0] line;
        logic [1:0]                   phase;
        logic                         vblank;
        logic                         hblank;
        logic                         match;
        logic                         draw_line;
        logic                         frame_ready;
    } t_line_status;

    logic [lcdst_pkg::ACCUM_W-1:0] accum_q;
    logic [1:0]                    phase_q;
    logic [lcdst_pkg::LINE_W-1:0]  line_q;
    logic                          vblank_q;
    logic                          hblank_q;
    logic                          match_q;
    logic [lcdst_pkg::LINE_W-1:0]  compare_q;

    t_line_status expected_status_q[$];
    int           mismatch_count = 0;

    assign o_errors = mismatch_count;

    function automatic logic [lcdst_pkg::LINE_W:0] close_line();
        logic [lcdst_pkg::LINE_W:0] nxt;
        while (accum_q >= lcdst_pkg::LINE_LEN) begin
            accum_q = accum_q - lcdst_pkg::LINE_LEN;
        end
        nxt = {1'b0, line_q} + 1'b1;
        line_q = (nxt >= lcdst_pkg::TOTAL_LINES) ? '0 : nxt[lcdst_pkg::LINE_W-1:0];
        match_q = (line_q == compare_q);
        return nxt;
    endfunction

    function automatic t_line_status advance_timing(input logic [9:0] elapsed);
        logic [9:0]                 mask;
        logic [lcdst_pkg::LINE_W:0] nxt;
        t_line_status               r;
        mask = 10'((1 << ELAPSED_BITS) - 1);
        r.draw_line = 1'b0;
        r.frame_ready = 1'b0;
        accum_q = accum_q + lcdst_pkg::ACCUM_W'(elapsed & mask);
        case (phase_q)
            lcdst_pkg::PHASE_CODE_HBLANK: begin
                if (accum_q >= lcdst_pkg::LINE_LEN) begin
                    nxt = close_line();
                    vblank_q = 1'b0;
                    hblank_q = 1'b0;
                    if (nxt == lcdst_pkg::VISIBLE_LINES) begin
                        phase_q = lcdst_pkg::PHASE_CODE_VBLANK;
                        vblank_q = 1'b1;
                        r.frame_ready = 1'b1;
                    end else begin
                        phase_q = lcdst_pkg::PHASE_CODE_DRAW;
                    end
                end
            end
            lcdst_pkg::PHASE_CODE_VBLANK: begin
                if (accum_q >= lcdst_pkg::LINE_LEN) begin
                    nxt = close_line();
                    if (nxt == lcdst_pkg::TOTAL_LINES) begin
                        phase_q = lcdst_pkg::PHASE_CODE_DRAW;
                        vblank_q = 1'b0;
                        hblank_q = 1'b0;
                    end
                end
            end
            default: begin
                if (accum_q >= lcdst_pkg::DRAW_END) begin
                    phase_q = lcdst_pkg::PHASE_CODE_HBLANK;
                    vblank_q = 1'b0;
                    hblank_q = 1'b1;
                    r.draw_line = 1'b1;
                end
            end
        endcase
        r.line = line_q;
        r.phase = phase_q;
        r.vblank = vblank_q;
        r.hblank = hblank_q;
        r.match = match_q;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_line_status want;
        if (!i_rst_n) begin
            accum_q = '0;
            phase_q = lcdst_pkg::PHASE_CODE_DRAW;
            line_q = '0;
            vblank_q = 1'b0;
            hblank_q = 1'b0;
            match_q = 1'b0;
            compare_q = '0;
            expected_status_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                compare_q = i_cfg_line_compare;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_status_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: status transaction with none expected, line %0d",
                             $time, i_line_number);
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("line_number", want.line, i_line_number);
                    check_field("phase", want.phase, i_phase);
                    check_field("vblank_flag", want.vblank, i_vblank_flag);
                    check_field("hblank_flag", want.hblank, i_hblank_flag);
                    check_field("line_match", want.match, i_line_match);
                    check_field("draw_line", want.draw_line, i_draw_line);
                    check_field("frame_ready", want.frame_ready, i_frame_ready);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_status_q.push_back(advance_timing(i_elapsed_cycles));
            end
            o_pending <= expected_status_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for lcd_scanline_timing_generator_unit
// depends on lcdst_pkg, the unit itself and lcdst_status_checker
module tb;

    localparam int unsigned ELAPSED_BITS = 10;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          PHASE_ITEMS  = 140;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [9:0] i_elapsed_cycles;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_line_compare;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_line_number;
    logic [1:0] o_phase;
    logic       o_vblank_flag;
    logic       o_hblank_flag;
    logic       o_line_match;
    logic       o_draw_line;
    logic       o_frame_ready;

    int         errors;
    int         pending;
    int         idle_cycles = 0;
    int         stall_left = 0;
    logic       calm = 1'b0;
    logic [7:0] last_line = '0;

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;
    wire cfg_fire = i_cfg_valid && o_cfg_ready;

    always #10 i_clk = ~i_clk;

    lcd_scanline_timing_generator_unit #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_elapsed_cycles  (i_elapsed_cycles),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_line_compare(i_cfg_line_compare),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_line_number     (o_line_number),
        .o_phase           (o_phase),
        .o_vblank_flag     (o_vblank_flag),
        .o_hblank_flag     (o_hblank_flag),
        .o_line_match      (o_line_match),
        .o_draw_line       (o_draw_line),
        .o_frame_ready     (o_frame_ready)
    );

    lcdst_status_checker #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_elapsed_cycles  (i_elapsed_cycles),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_line_compare(i_cfg_line_compare),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_line_number     (o_line_number),
        .i_phase           (o_phase),
        .i_vblank_flag     (o_vblank_flag),
        .i_hblank_flag     (o_hblank_flag),
        .i_line_match      (o_line_match),
        .i_draw_line       (o_draw_line),
        .i_frame_ready     (o_frame_ready),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [9:0] rand_elapsed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return 10'd0;
        end else if (pick < 10) begin
            return 10'd1023;
        end else if (pick < 20) begin
            return 10'($urandom_range(0, 255));
        end else if (pick < 30) begin
            return 10'($urandom);
        end
        return 10'($urandom_range(700, 1023));
    endfunction

    // receiver back-pressure, with calm stretches of no stalls
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) begin
            calm <= ~calm;
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= pick_gap() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (out_fire) begin
            last_line <= o_line_number;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire || cfg_fire) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("** lcd_scanline_timing_generator_unit: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_elapsed(input logic [9:0] value);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elapsed_cycles <= value;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_compare(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_line_compare <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] compare;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_elapsed_cycles = '0;
        i_cfg_valid = 1'b0;
        i_cfg_line_compare = '0;
        i_out_ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // match stays low on line 0 until the first line change
        write_compare(8'd0);
        send_elapsed(10'd0);
        send_elapsed(10'd959);
        // draw ends past the line length, the line closes one step later
        send_elapsed(10'd1023);
        // two subtractions of the line length
        send_elapsed(10'd1023);
        send_elapsed(10'd0);
        send_elapsed(10'd419);
        send_elapsed(10'd271);
        send_elapsed(10'd1);
        send_elapsed(10'd1023);
        send_elapsed(10'd512);
        send_elapsed(10'd1023);
        send_elapsed(10'd1023);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       compare = 8'd255;
                2:       compare = 8'd160;
                4:       compare = 8'd0;
                default: compare = 8'((last_line + $urandom_range(1, 20)) % 228);
            endcase
            write_compare(compare);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_elapsed(rand_elapsed());
            end
            drain();
        end

        repeat (5) @(negedge i_clk);
        if (errors == 0) begin
            $display("** lcd_scanline_timing_generator_unit: PASSED **");
        end else begin
            $display("** lcd_scanline_timing_generator_unit: FAILED **");
        end
        $finish;
    end

endmodule
